/* hdl/mbet_pkg.sv */
package mbet_pkg;

    // Fixed-point format of the complex values (signed, Q4.28 by default)
    localparam int FRAC_BITS = 28;

    // Default number of pixel coordinate bits that take part in the mapping
    localparam int COORD_BITS_DEF = 12;

    // Field widths of the stream and register payloads
    localparam int PIX_BITS   = 12;
    localparam int LIMIT_BITS = 16;
    localparam int STEP_BITS  = 28;
    localparam int ORIG_BITS  = 32;
    localparam int LEVEL_BITS = 8;
    localparam int CFG_ADDR_BITS = 8;
    localparam int CFG_DATA_BITS = 32;

    // Operand width of the shared multiplier: |z| <= 2.0 fits in FRAC_BITS+2 bits
    localparam int MUL_W = FRAC_BITS + 2;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_ITER_LIMIT = 8'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PIXEL_STEP = 8'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_RE  = 8'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_IM  = 8'd3;

    // Register values after reset
    localparam logic [LIMIT_BITS-1:0]       RST_ITER_LIMIT = 16'd500;
    localparam logic [STEP_BITS-1:0]        RST_PIXEL_STEP = 28'd1342177;
    localparam logic signed [ORIG_BITS-1:0] RST_ORIGIN_RE  = -32'sd536870912;
    localparam logic signed [ORIG_BITS-1:0] RST_ORIGIN_IM  = -32'sd536870912;

endpackage

/* hdl/mbet_mul.sv */
module mbet_mul #(
    parameter int WIDTH = mbet_pkg::MUL_W
) (
    input  logic                 i_clk,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    input  logic                 i_neg,
    output logic [2*WIDTH-1:0]   o_prod,
    output logic                 o_neg
);
    import mbet_pkg::*;

    logic [2*WIDTH-1:0] r_prod;
    logic               r_neg;

    // Register the magnitude product and the sign it carries
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_neg  <= i_neg;
    end

    assign o_prod = r_prod;
    assign o_neg  = r_neg;

endmodule

/* hdl/mbet_div.sv */
module mbet_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mbet_pkg::LIMIT_BITS-1:0]    i_count,
    input  logic [mbet_pkg::LIMIT_BITS-1:0]    i_limit,
    output logic                               o_done,
    output logic [mbet_pkg::LEVEL_BITS-1:0]    o_level
);
    import mbet_pkg::*;

    // count*255 needs LIMIT_BITS+8 bits; quotient stays below 256 since count < limit
    localparam int NUM_W  = LIMIT_BITS + LEVEL_BITS;
    localparam int STEP_W = $clog2(LEVEL_BITS);

    logic [NUM_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_den;
    logic [LEVEL_BITS-1:0] r_quot;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_zero;
    logic                  fits;

    assign fits = (r_rem >= r_den);

    // Control: run one quotient bit per cycle, flag the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(LEVEL_BITS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: restoring division with the divisor walking down one bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {i_count, LEVEL_BITS'(0)} - NUM_W'(i_count);
            r_den  <= NUM_W'({i_limit, (LEVEL_BITS - 1)'(0)});
            r_quot <= '0;
            r_step <= '0;
            r_zero <= (i_limit == '0);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[LEVEL_BITS-2:0], fits};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_done  = r_done;
    assign o_level = r_zero ? '0 : r_quot;

endmodule

/* hdl/mandelbrot_escape_time_pixel.sv */
// Mandelbrot escape-time evaluator, one pixel at a time. Each input transaction carries a pixel
// column and row; the block maps them to c = origin + coordinate * pixel_step and iterates
// z = z*z + c in signed fixed point with FRAC_BITS fraction bits for up to iteration_limit steps.
// The result transaction echoes the coordinates and returns the step index at which |z|^2 first
// exceeded 4 (zero if it never did), plus a blue level of escape_count*255/iteration_limit.
// Sequence: each iteration steps through S_UPD, S_SQR, S_SQI and S_CROSS, as its three
// products (re^2, im^2, re*im) go one after another through a single 30x30 multiplier
// and the update follows; the pixel mapping uses the same multiplier. An input transaction
// passes the mapping states S_CR, S_CI and S_START, the loop with its closing update, the
// 8-step blue-level divider and the hand-off to the output register. A point caught by the
// magnitude test skips the closing update. With the output free, the input is ready again
// in the same cycle that the result appears on the output. The input is ready only while
// the block is idle; a finished result waits in the output register so the next pixel can
// start. Configuration writes are accepted at any time and should be made idle.
module mandelbrot_escape_time_pixel #(
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Pixel input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [23:0]                           s_axis_tdata,   // pixel_x, pixel_y
    // Result output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [47:0]                           m_axis_tdata,   // out_x, out_y,
                                                                  // escape_count, blue_level
    // Register write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mbet_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [mbet_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import mbet_pkg::*;

    // Coordinate bits used in the mapping, never more than the field carries
    localparam int PX_BITS = (COORD_BITS < PIX_BITS) ? COORD_BITS : PIX_BITS;
    localparam int PW      = PX_BITS + STEP_BITS;
    localparam int CW      = ((PW > ORIG_BITS - 1) ? PW : ORIG_BITS - 1) + 2;
    localparam int ZW      = CW + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQW     = FRAC_BITS + 3;
    localparam int XW      = FRAC_BITS + 4;

    localparam logic signed [ZW-1:0] TWO  = ZW'(1) << (FRAC_BITS + 1);
    localparam logic [SQW:0]         FOUR = (SQW + 1)'(1) << (FRAC_BITS + 2);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CR    = 11'b000_0000_0010,
        S_CI    = 11'b000_0000_0100,
        S_START = 11'b000_0000_1000,
        S_UPD   = 11'b000_0001_0000,
        S_SQR   = 11'b000_0010_0000,
        S_SQI   = 11'b000_0100_0000,
        S_CROSS = 11'b000_1000_0000,
        S_DIVGO = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [LIMIT_BITS-1:0]       r_limit;
    logic [STEP_BITS-1:0]        r_step;
    logic signed [ORIG_BITS-1:0] r_orig_re;
    logic signed [ORIG_BITS-1:0] r_orig_im;

    // Pixel working registers
    logic [PIX_BITS-1:0]   r_px, r_py;
    logic signed [CW-1:0]  r_cr, r_ci;
    logic signed [ZW-1:0]  r_zr, r_zi;
    logic [SQW-1:0]        r_rr, r_ii;
    logic [LIMIT_BITS-1:0] r_iter;
    logic [LIMIT_BITS-1:0] r_count;

    // Output register
    logic                  r_out_valid;
    logic [47:0]           r_out_data;

    // Shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              mul_neg;
    logic [PROD_W-1:0] prod;
    logic              prod_neg;

    // Divider
    logic                  div_done;
    logic [LEVEL_BITS-1:0] div_level;

    // Update datapath
    logic [MUL_W-1:0]      abs_zr, abs_zi;
    logic [SQW-1:0]        sq_now;
    logic [XW-1:0]         cross_mag;
    logic signed [ZW-1:0]  cross_val;
    logic signed [ZW-1:0]  nr, ni;
    logic                  out_of_box;
    logic [SQW:0]          mag_sum;
    logic                  in_fire, out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= RST_ITER_LIMIT;
            r_step    <= RST_PIXEL_STEP;
            r_orig_re <= RST_ORIGIN_RE;
            r_orig_im <= RST_ORIGIN_IM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_ITER_LIMIT: r_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                REG_PIXEL_STEP: r_step    <= i_cfg_data[STEP_BITS-1:0];
                REG_ORIGIN_RE:  r_orig_re <= i_cfg_data[ORIG_BITS-1:0];
                REG_ORIGIN_IM:  r_orig_im <= i_cfg_data[ORIG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Magnitudes of z; only used once |re|,|im| <= 2 is known
    assign abs_zr = r_zr[ZW-1] ? MUL_W'(-r_zr) : MUL_W'(r_zr);
    assign abs_zi = r_zi[ZW-1] ? MUL_W'(-r_zi) : MUL_W'(r_zi);

    // Feed the shared multiplier according to the step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (r_state)
            S_CR: begin
                mul_a = MUL_W'(r_px[PX_BITS-1:0]);
                mul_b = MUL_W'(r_step);
            end
            S_CI: begin
                mul_a = MUL_W'(r_py[PX_BITS-1:0]);
                mul_b = MUL_W'(r_step);
            end
            S_SQR: begin
                mul_a = abs_zr;
                mul_b = abs_zr;
            end
            S_SQI: begin
                mul_a = abs_zi;
                mul_b = abs_zi;
            end
            S_CROSS: begin
                mul_a   = abs_zr;
                mul_b   = abs_zi;
                mul_neg = r_zr[ZW-1] ^ r_zi[ZW-1];
            end
            default: ;
        endcase
    end

    mbet_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_neg  (mul_neg),
        .o_prod (prod),
        .o_neg  (prod_neg)
    );

    // Truncate products toward zero; the cross term folds in the factor of two
    assign sq_now    = prod[FRAC_BITS+SQW-1:FRAC_BITS];
    assign cross_mag = prod[FRAC_BITS-1+XW-1:FRAC_BITS-1];
    assign cross_val = prod_neg ? -$signed(ZW'(cross_mag)) : $signed(ZW'(cross_mag));

    // Next z and escape tests
    assign ni         = cross_val + ZW'(r_ci);
    assign nr         = $signed(ZW'(r_rr)) - $signed(ZW'(r_ii)) + ZW'(r_cr);
    assign out_of_box = (nr > TWO) || (nr < -TWO) || (ni > TWO) || (ni < -TWO);
    assign mag_sum    = (SQW + 1)'(r_rr) + (SQW + 1)'(sq_now);

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_CR;
            S_CR:    n_state = S_CI;
            S_CI:    n_state = S_START;
            S_START: n_state = S_UPD;
            S_UPD: begin
                if ((r_iter == r_limit) || out_of_box) begin
                    n_state = S_DIVGO;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_SQR:   n_state = S_SQI;
            S_SQI:   n_state = S_CROSS;
            S_CROSS: n_state = (mag_sum > FOUR) ? S_DIVGO : S_UPD;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Working registers of the iteration
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_px <= s_axis_tdata[PIX_BITS-1:0];
                    r_py <= s_axis_tdata[2*PIX_BITS-1:PIX_BITS];
                end
            end
            S_CI: begin
                r_cr <= CW'(r_orig_re) + $signed(CW'(prod[PW-1:0]));
            end
            S_START: begin
                r_ci   <= CW'(r_orig_im) + $signed(CW'(prod[PW-1:0]));
                r_rr   <= '0;
                r_ii   <= '0;
                r_iter <= '0;
            end
            S_UPD: begin
                if (r_iter == r_limit) begin
                    r_count <= '0;
                end else if (out_of_box) begin
                    r_count <= r_iter;
                end else begin
                    r_zr <= nr;
                    r_zi <= ni;
                end
            end
            S_SQI: begin
                r_rr <= sq_now;
            end
            S_CROSS: begin
                r_ii <= sq_now;
                if (mag_sum > FOUR) begin
                    r_count <= r_iter;
                end else begin
                    r_iter <= r_iter + LIMIT_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // Blue level = count*255/limit
    mbet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_count (r_count),
        .i_limit (r_limit),
        .o_done  (div_done),
        .o_level (div_level)
    );

    // Hold the finished result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_data <= {div_level, r_count, r_py, r_px};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
